>>> rtl/core/extent_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the extent free list allocator
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef EXTENT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define EXTENT_FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define EFLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define EFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define EFLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define EFLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/efla_pkg.sv
// ----------------------------------------------------------------------------
// Extent free list allocator package
// Widths, command and status codes shared by the allocator files.
// ----------------------------------------------------------------------------
package efla_pkg;

	localparam int ADDRESS_BITS = 48;
	localparam int DEPTH_DEF    = 16;

	typedef logic [ADDRESS_BITS-1:0] addr_t;
	typedef logic [1:0]              cmd_t;
	typedef logic [2:0]              status_t;

	localparam cmd_t CMD_ALLOC = 2'd0;
	localparam cmd_t CMD_FREE  = 2'd1;
	localparam cmd_t CMD_TRIM  = 2'd2;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_NO_SPACE = 3'd1;
	localparam status_t ST_NO_FIT   = 3'd3;
	localparam status_t ST_OFF_FIT  = 3'd4;
	localparam status_t ST_FULL     = 3'd5;

	localparam logic REG_START  = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

endpackage

>>> rtl/core/efla_stream_if.sv
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface efla_req_if;
	import efla_pkg::*;
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	addr_t req_size;
	logic  size_given;
	addr_t req_offset;
	logic  offset_given;
	addr_t trim_amount;
	modport source (output valid, cmd, req_size, size_given, req_offset, offset_given,
		trim_amount, input ready);
	modport sink (input valid, cmd, req_size, size_given, req_offset, offset_given,
		trim_amount, output ready);
endinterface

interface efla_rsp_if;
	import efla_pkg::*;
	logic       valid;
	logic       ready;
	status_t    status;
	addr_t      granted_size;
	addr_t      granted_offset;
	addr_t      avail_bytes;
	logic [4:0] extent_total;
	logic [7:0] allocated_count;
	modport source (output valid, status, granted_size, granted_offset, avail_bytes,
		extent_total, allocated_count, input ready);
	modport sink (input valid, status, granted_size, granted_offset, avail_bytes,
		extent_total, allocated_count, output ready);
endinterface

>>> rtl/core/extent_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Extent free list allocator
// First-fit allocator over a table of free extents sorted by offset; with no size given it takes the largest extent.
// ----------------------------------------------------------------------------
// The free extent table lives in one RAM with a registered read. Each
// transaction is handled alone: it scans the table one entry per cycle,
// an allocate scans it twice, and an insert or remove moves entries one
// at a time, each read and then written back. Writing a configuration
// register reloads the table with one extent at once.
`include "extent_free_list_allocator_macros.svh"

module extent_free_list_allocator #(
	parameter int TABLE_DEPTH = efla_pkg::DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  efla_pkg::addr_t       cfg_data,
	efla_req_if.sink              req,
	efla_rsp_if.source            rsp
);
	import efla_pkg::*;

	localparam int AW = ADDRESS_BITS;
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN    = 4'd1;
	localparam logic [3:0] S_DECIDE  = 4'd2;
	localparam logic [3:0] S_APPLY   = 4'd3;
	localparam logic [3:0] S_SHUP    = 4'd4;
	localparam logic [3:0] S_SHUP_WR = 4'd5;
	localparam logic [3:0] S_SHDN    = 4'd6;
	localparam logic [3:0] S_SHDN_WR = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]    state_q;
	addr_t         start_q, length_q, free_q;
	logic [7:0]    live_q;
	logic [CW-1:0] used_q;

	cmd_t          cmd_q;
	addr_t         size_q, off_q, rem_q;
	logic          sg_q, og_q;
	logic          pass_q;
	logic          found_q, pf_q;
	logic [IW-1:0] sel_q, pos_q;
	addr_t         sel_off_q, sel_len_q;
	logic [CW-1:0] cnt_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic [IW-1:0] sh_q, ins_pos_q;
	addr_t         ins_off_q, ins_len_q;
	status_t       st_q;
	addr_t         gs_q, go_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	addr_t             rsp_gs_q, rsp_go_q, rsp_avail_q;
	logic [4:0]        rsp_total_q;
	logic [7:0]        rsp_live_q;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	logic [2*AW-1:0]   ram_wdata, rd_data;

	efla_ram #(.WIDTH(2 * AW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	addr_t       e_off, e_len, new_start, new_len, trim_key, new_sel_len;
	logic [AW:0] e_end, q_end, sel_end;
	logic        issue, scan_done, full, split, shdn_more;
	logic [IW-1:0] ins_pos_free;
	logic [CW+4:0] used_wide;

	assign e_off        = rd_data[2*AW-1:AW];
	assign e_len        = rd_data[AW-1:0];
	assign e_end        = {1'b0, e_off} + {1'b0, e_len};
	assign q_end        = {1'b0, off_q} + {1'b0, size_q};
	assign sel_end      = {1'b0, sel_off_q} + {1'b0, sel_len_q};
	assign trim_key     = off_q + size_q - rem_q;
	assign new_sel_len  = sel_len_q - size_q;
	assign new_start    = (cfg_index == REG_START) ? cfg_data : start_q;
	assign new_len      = (cfg_index == REG_LENGTH) ? cfg_data : length_q;
	assign issue        = (state_q == S_SCAN) && (cnt_q < used_q);
	assign scan_done    = (state_q == S_SCAN) && !issue && !v_s1;
	assign full         = used_q == CW'(TABLE_DEPTH);
	assign split        = q_end != sel_end;
	assign ins_pos_free = pf_q ? pos_q : used_q[IW-1:0];
	assign shdn_more    = ({{(CW + 1 - IW){1'b0}}, sh_q} + (CW + 1)'(1)) < {1'b0, used_q};
	assign used_wide    = {5'd0, used_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				ram_we    = cfg_we;
				ram_wdata = {new_start, new_len};
			end
			S_SCAN: begin
				ram_raddr = cnt_q[IW-1:0];
			end
			S_DECIDE: begin
				ram_waddr = sel_q;
				if (cmd_q == CMD_FREE && found_q) begin
					ram_we    = 1'b1;
					ram_wdata = {(sel_off_q > off_q) ? off_q : sel_off_q,
						sel_len_q + size_q};
				end else if (cmd_q == CMD_TRIM && found_q) begin
					ram_we    = 1'b1;
					ram_wdata = {sel_off_q - rem_q, sel_len_q + rem_q};
				end
			end
			S_APPLY: begin
				ram_waddr = sel_q;
				if (found_q) begin
					if (sel_off_q == off_q) begin
						ram_we    = new_sel_len != '0;
						ram_wdata = {q_end[AW-1:0], new_sel_len};
					end else begin
						ram_we    = !(split && full);
						ram_wdata = {sel_off_q, off_q - sel_off_q};
					end
				end
			end
			S_SHUP: begin
				ram_raddr = sh_q - IW'(1);
				ram_waddr = ins_pos_q;
				ram_we    = !(sh_q > ins_pos_q);
				ram_wdata = {ins_off_q, ins_len_q};
			end
			S_SHUP_WR, S_SHDN_WR: begin
				ram_we    = 1'b1;
				ram_waddr = sh_q;
				ram_wdata = rd_data;
			end
			S_SHDN: begin
				ram_raddr = sh_q + IW'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign req.ready           = state_q == S_IDLE;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.granted_size    = rsp_gs_q;
	assign rsp.granted_offset  = rsp_go_q;
	assign rsp.avail_bytes     = rsp_avail_q;
	assign rsp.extent_total    = rsp_total_q;
	assign rsp.allocated_count = rsp_live_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q   <= req.cmd;
			size_q  <= req.req_size;
			off_q   <= req.req_offset;
			sg_q    <= req.size_given;
			og_q    <= req.offset_given;
			rem_q   <= (req.trim_amount > req.req_size) ? req.req_size : req.trim_amount;
		end else if (state_q == S_SCAN && v_s1) begin
			if (pass_q) begin
				if (!found_q && e_off <= off_q && e_end >= q_end) begin
					sel_q     <= idx_s1;
					sel_off_q <= e_off;
					sel_len_q <= e_len;
				end
			end else begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (!sg_q && (!found_q || e_len >= size_q)) begin
							size_q <= e_len;
							off_q  <= e_off;
						end
						if (sg_q && !found_q && e_len >= size_q) begin
							sel_q     <= idx_s1;
							sel_off_q <= e_off;
							sel_len_q <= e_len;
						end
					end
					CMD_FREE: begin
						if (!found_q && ({1'b0, e_off} == q_end || e_end == {1'b0, off_q})) begin
							sel_q     <= idx_s1;
							sel_off_q <= e_off;
							sel_len_q <= e_len;
						end
						if (!pf_q && off_q < e_off) begin
							pos_q <= idx_s1;
						end
					end
					CMD_TRIM: begin
						if (!found_q && {1'b0, e_off} == q_end) begin
							sel_q     <= idx_s1;
							sel_off_q <= e_off;
							sel_len_q <= e_len;
						end
						if (!pf_q && trim_key < e_off) begin
							pos_q <= idx_s1;
						end
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end
		end else if (state_q == S_DECIDE && cmd_q == CMD_ALLOC && sg_q && !og_q) begin
			off_q <= sel_off_q;
		end
		idx_s1 <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= '0;
			length_q    <= '0;
			free_q      <= '0;
			live_q      <= '0;
			used_q      <= '0;
			pass_q      <= 1'b0;
			found_q     <= 1'b0;
			pf_q        <= 1'b0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			sh_q        <= '0;
			ins_pos_q   <= '0;
			ins_off_q   <= '0;
			ins_len_q   <= '0;
			st_q        <= ST_OK;
			gs_q        <= '0;
			go_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_gs_q    <= '0;
			rsp_go_q    <= '0;
			rsp_avail_q <= '0;
			rsp_total_q <= '0;
			rsp_live_q  <= '0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_SCAN && v_s1) begin
				if (pass_q) begin
					if (!found_q && e_off <= off_q && e_end >= q_end) begin
						found_q <= 1'b1;
					end
				end else begin
					case (cmd_q)
						CMD_ALLOC: begin
							if ((!sg_q) || e_len >= size_q) begin
								found_q <= 1'b1;
							end
						end
						CMD_FREE: begin
							if ({1'b0, e_off} == q_end || e_end == {1'b0, off_q}) begin
								found_q <= 1'b1;
							end
							if (off_q < e_off) begin
								pf_q <= 1'b1;
							end
						end
						CMD_TRIM: begin
							if ({1'b0, e_off} == q_end) begin
								found_q <= 1'b1;
							end
							if (trim_key < e_off) begin
								pf_q <= 1'b1;
							end
						end
						default: begin
							found_q <= found_q;
						end
					endcase
				end
			end
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						if (cfg_index == REG_START) begin
							start_q <= cfg_data;
						end else begin
							length_q <= cfg_data;
						end
						used_q <= (new_len != '0) ? CW'(1) : CW'(0);
						free_q <= new_len;
						live_q <= '0;
					end
					if (req.valid) begin
						go_q    <= '0;
						found_q <= 1'b0;
						pf_q    <= 1'b0;
						pass_q  <= 1'b0;
						cnt_q   <= '0;
						case (req.cmd)
							CMD_ALLOC: begin
								gs_q <= '0;
								if ((req.size_given && req.req_size > free_q) ||
									used_q == '0) begin
									st_q    <= ST_NO_SPACE;
									state_q <= S_FIN;
								end else begin
									st_q    <= ST_OK;
									state_q <= S_SCAN;
								end
							end
							CMD_FREE: begin
								st_q    <= ST_OK;
								gs_q    <= '0;
								state_q <= S_SCAN;
							end
							CMD_TRIM: begin
								st_q <= ST_OK;
								if (req.trim_amount == '0 || req.req_size == '0) begin
									gs_q    <= req.req_size;
									state_q <= S_FIN;
								end else begin
									gs_q    <= '0;
									state_q <= S_SCAN;
								end
							end
							default: begin
								st_q    <= ST_OK;
								gs_q    <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= pass_q ? S_APPLY : S_DECIDE;
					end
				end
				S_DECIDE: begin
					case (cmd_q)
						CMD_ALLOC: begin
							if (sg_q && !found_q) begin
								st_q    <= ST_NO_FIT;
								state_q <= S_FIN;
							end else begin
								found_q <= 1'b0;
								pass_q  <= 1'b1;
								cnt_q   <= '0;
								state_q <= S_SCAN;
							end
						end
						CMD_FREE: begin
							if (!found_q && full) begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end else begin
								free_q <= free_q + size_q;
								live_q <= live_q - 8'd1;
								if (!found_q) begin
									ins_pos_q <= ins_pos_free;
									ins_off_q <= off_q;
									ins_len_q <= size_q;
									sh_q      <= used_q[IW-1:0];
									state_q   <= S_SHUP;
								end else begin
									state_q   <= S_FIN;
								end
							end
						end
						default: begin
							if (!found_q && full) begin
								st_q    <= ST_FULL;
								state_q <= S_FIN;
							end else begin
								free_q <= free_q + rem_q;
								gs_q   <= size_q - rem_q;
								if (!found_q) begin
									ins_pos_q <= ins_pos_free;
									ins_off_q <= trim_key;
									ins_len_q <= rem_q;
									sh_q      <= used_q[IW-1:0];
									state_q   <= S_SHUP;
								end else begin
									state_q   <= S_FIN;
								end
							end
						end
					endcase
				end
				S_APPLY: begin
					if (!found_q) begin
						st_q    <= ST_OFF_FIT;
						state_q <= S_FIN;
					end else if (sel_off_q != off_q && split && full) begin
						st_q    <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						live_q <= live_q + 8'd1;
						free_q <= free_q - size_q;
						gs_q   <= size_q;
						go_q   <= off_q;
						if (sel_off_q == off_q) begin
							if (new_sel_len == '0) begin
								sh_q    <= sel_q;
								state_q <= S_SHDN;
							end else begin
								state_q <= S_FIN;
							end
						end else if (split) begin
							ins_pos_q <= sel_q + IW'(1);
							ins_off_q <= q_end[AW-1:0];
							ins_len_q <= sel_end[AW-1:0] - q_end[AW-1:0];
							sh_q      <= used_q[IW-1:0];
							state_q   <= S_SHUP;
						end else begin
							state_q   <= S_FIN;
						end
					end
				end
				S_SHUP: begin
					if (sh_q > ins_pos_q) begin
						state_q <= S_SHUP_WR;
					end else begin
						used_q  <= used_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SHUP_WR: begin
					sh_q    <= sh_q - IW'(1);
					state_q <= S_SHUP;
				end
				S_SHDN: begin
					if (shdn_more) begin
						state_q <= S_SHDN_WR;
					end else begin
						used_q  <= used_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_SHDN_WR: begin
					sh_q    <= sh_q + IW'(1);
					state_q <= S_SHDN;
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= st_q;
						rsp_gs_q     <= (st_q == ST_OK) ? gs_q : '0;
						rsp_go_q     <= (st_q == ST_OK) ? go_q : '0;
						rsp_avail_q  <= free_q;
						rsp_total_q  <= used_wide[4:0];
						rsp_live_q   <= live_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`EFLA_ASSERT_SAME(a_used_bound, clk, arst_n, 1'b1, used_q <= CW'(TABLE_DEPTH), "extent count exceeds table depth")
	`EFLA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, state_q != S_IDLE, "block idle right after a transaction")
	`EFLA_ASSERT_SAME(a_no_write_in_scan, clk, arst_n, state_q == S_SCAN, !ram_we, "table written during a scan")
endmodule

>>> rtl/core/efla_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module efla_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> dv/extent_free_list_allocator_tb.sv
// ----------------------------------------------------------------------------
// Extent free list allocator testbench
// Drives allocate, free and trim commands, and the unused command code, into the
// allocator and checks every response against a cycle-free model of the sorted
// free extent table or, for typed directed rows, against fixed expected values. A
// short directed table comes first, then random traffic over several region setups.
`timescale 1ns / 100ps

module extent_free_list_allocator_tb;
	import efla_pkg::*;

	localparam int      DEPTH        = DEPTH_DEF;
	localparam int      CYCLE_LIMIT  = 1000000;
	localparam int      DRAIN_CYCLES = 4 * DEPTH + 20;
	localparam int      RAND_ITEMS   = 125;
	localparam int      PHASES       = 6;
	localparam addr_t   AMAX         = '1;
	localparam cmd_t    CMD_NONE     = 2'd3;
	localparam status_t ST_AUTO_FAIL = 3'd2;

	typedef struct {
		cmd_t  cmd;
		addr_t size;
		logic  size_given;
		addr_t offset;
		logic  offset_given;
		addr_t trim;
	} request_t;

	typedef struct {
		status_t    status;
		addr_t      gsize;
		addr_t      goffset;
		addr_t      avail;
		logic [4:0] extents;
		logic [7:0] allocs;
	} response_t;

	typedef struct {
		bit        is_cfg;
		addr_t     cfg_start;
		addr_t     cfg_length;
		request_t  rq;
		bit        typed;
		response_t rs;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	addr_t cfg_data;

	efla_req_if req_ch ();
	efla_rsp_if rsp_ch ();

	extent_free_list_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	addr_t      ext_off [DEPTH];
	addr_t      ext_len [DEPTH];
	int         ext_used;
	addr_t      free_bytes;
	logic [7:0] live_cnt;
	addr_t      region_base;
	addr_t      region_len;

	response_t  pending_rsp[$];
	addr_t      grant_off[$];
	addr_t      grant_len[$];
	dir_row_t   dir_tab[$];

	int  errors;
	int  sent_cnt;
	int  rsp_cnt;
	int  cycles;
	int  tx_idle;
	int  rx_idle;
	bit  hold_req;
	bit  hold_done;
	int  hold_left;
	int  status_seen [8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("extent_free_list_allocator verification failed");
			$finish;
		end
	end

	function automatic addr_t rand48();
		return addr_t'({$urandom(), $urandom()});
	endfunction

	function automatic void table_load();
		for (int i = 0; i < DEPTH; i++) begin
			ext_off[i] = '0;
			ext_len[i] = '0;
		end
		ext_off[0] = region_base;
		ext_len[0] = region_len;
		ext_used = (region_len != 0) ? 1 : 0;
		free_bytes = region_len;
		live_cnt = '0;
	endfunction

	function automatic void table_insert(int pos, logic [63:0] o, logic [63:0] l);
		for (int i = ext_used; i > pos; i--) begin
			ext_off[i] = ext_off[i-1];
			ext_len[i] = ext_len[i-1];
		end
		ext_off[pos] = addr_t'(o);
		ext_len[pos] = addr_t'(l);
		ext_used++;
	endfunction

	function automatic int ordered_slot(addr_t o);
		for (int i = 0; i < ext_used; i++)
			if (o < ext_off[i])
				return i;
		return ext_used;
	endfunction

	// Applies one command to the extent table and returns the response it causes.
	function automatic response_t allocator_step(request_t r);
		response_t   res;
		logic [63:0] sz;
		logic [63:0] of;
		logic [63:0] rem;
		logic [63:0] endp;
		logic [63:0] gs;
		logic [63:0] go;
		bit          og;
		bit          found;
		int          sel;
		sz = r.size;
		of = r.offset;
		og = r.offset_given;
		found = 0;
		sel = 0;
		gs = 0;
		go = 0;
		res.status = ST_OK;
		if (r.cmd == CMD_ALLOC) begin
			if ((r.size_given && sz > free_bytes) || ext_used == 0) begin
				res.status = ST_NO_SPACE;
			end else begin
				if (!r.size_given) begin
					for (int i = 0; i < ext_used; i++) begin
						if (!found || ext_len[i] >= sz) begin
							sz = ext_len[i];
							of = ext_off[i];
							sel = i;
							found = 1;
						end
					end
					if (!found)
						res.status = ST_AUTO_FAIL;
					og = 1;
				end else begin
					for (int i = 0; i < ext_used && !found; i++) begin
						if (ext_len[i] >= sz) begin
							sel = i;
							found = 1;
						end
					end
					if (!found)
						res.status = ST_NO_FIT;
					else if (!og)
						of = ext_off[sel];
				end
				if (res.status == ST_OK && og) begin
					found = 0;
					for (int i = 0; i < ext_used && !found; i++) begin
						if (ext_off[i] <= of && 64'(ext_off[i]) + ext_len[i] >= of + sz) begin
							sel = i;
							found = 1;
						end
					end
					if (!found)
						res.status = ST_OFF_FIT;
				end
				if (res.status == ST_OK) begin
					if (ext_off[sel] == of) begin
						ext_off[sel] = addr_t'(ext_off[sel] + sz);
						ext_len[sel] = addr_t'(ext_len[sel] - sz);
						if (ext_len[sel] == 0) begin
							for (int i = sel; i + 1 < ext_used; i++) begin
								ext_off[i] = ext_off[i+1];
								ext_len[i] = ext_len[i+1];
							end
							ext_used--;
						end
					end else begin
						endp = 64'(ext_off[sel]) + ext_len[sel];
						if (of + sz != endp) begin
							if (ext_used >= DEPTH) begin
								res.status = ST_FULL;
							end else begin
								ext_len[sel] = addr_t'(of - ext_off[sel]);
								table_insert(sel + 1, of + sz, endp - (of + sz));
							end
						end else begin
							ext_len[sel] = addr_t'(of - ext_off[sel]);
						end
					end
				end
				if (res.status == ST_OK) begin
					live_cnt = live_cnt + 8'd1;
					free_bytes = addr_t'(free_bytes - sz);
					gs = sz;
					go = of;
				end
			end
		end else if (r.cmd == CMD_FREE) begin
			for (int i = 0; i < ext_used && !found; i++) begin
				if (64'(ext_off[i]) == of + sz || 64'(ext_off[i]) + ext_len[i] == of) begin
					sel = i;
					found = 1;
				end
			end
			if (found) begin
				ext_len[sel] = addr_t'(ext_len[sel] + sz);
				if (ext_off[sel] > of)
					ext_off[sel] = addr_t'(of);
			end else if (ext_used >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				table_insert(ordered_slot(addr_t'(of)), of, sz);
			end
			if (res.status == ST_OK) begin
				free_bytes = addr_t'(free_bytes + sz);
				live_cnt = live_cnt - 8'd1;
			end
		end else if (r.cmd == CMD_TRIM) begin
			rem = r.trim;
			if (rem > sz)
				rem = sz;
			endp = of + sz;
			if (rem != 0) begin
				for (int i = 0; i < ext_used && !found; i++) begin
					if (64'(ext_off[i]) == endp) begin
						sel = i;
						found = 1;
					end
				end
				if (found) begin
					ext_off[sel] = addr_t'(ext_off[sel] - rem);
					ext_len[sel] = addr_t'(ext_len[sel] + rem);
				end else if (ext_used >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					table_insert(ordered_slot(addr_t'(endp - rem)), endp - rem, rem);
				end
				if (res.status == ST_OK)
					free_bytes = addr_t'(free_bytes + rem);
			end
			gs = sz - rem;
		end
		if (res.status != ST_OK) begin
			gs = 0;
			go = 0;
		end
		res.gsize = addr_t'(gs);
		res.goffset = addr_t'(go);
		res.avail = free_bytes;
		res.extents = ext_used[4:0];
		res.allocs = live_cnt;
		return res;
	endfunction

	function automatic void check_field(string name, addr_t exp_v, addr_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		response_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_cnt++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with nothing expected, actual status %0d", $time,
					rsp_ch.status);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				status_seen[e.status]++;
				check_field("status", addr_t'(e.status), addr_t'(rsp_ch.status));
				check_field("granted_size", e.gsize, rsp_ch.granted_size);
				check_field("granted_offset", e.goffset, rsp_ch.granted_offset);
				check_field("avail_bytes", e.avail, rsp_ch.avail_bytes);
				check_field("extent_total", addr_t'(e.extents), addr_t'(rsp_ch.extent_total));
				check_field("allocated_count", addr_t'(e.allocs),
					addr_t'(rsp_ch.allocated_count));
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send(request_t r, bit typed, response_t typed_rs);
		response_t p;
		p = allocator_step(r);
		pending_rsp.push_back(typed ? typed_rs : p);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.req_size <= r.size;
		req_ch.size_given <= r.size_given;
		req_ch.req_offset <= r.offset;
		req_ch.offset_given <= r.offset_given;
		req_ch.trim_amount <= r.trim;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent_cnt++;
		if ($urandom_range(99) < tx_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic load_region(addr_t base, addr_t len);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_START;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= REG_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		region_base = base;
		region_len = len;
		table_load();
		grant_off.delete();
		grant_len.delete();
	endtask

	function automatic dir_row_t row(cmd_t c, addr_t s, logic sg, addr_t o, logic og,
		addr_t t, bit typed = 0, status_t st = ST_OK, addr_t gs = 0, addr_t go = 0,
		addr_t av = 0, logic [4:0] ex = 0, logic [7:0] cnt = 0);
		dir_row_t d;
		d.is_cfg = 0;
		d.cfg_start = '0;
		d.cfg_length = '0;
		d.rq = '{c, s, sg, o, og, t};
		d.typed = typed;
		d.rs = '{st, gs, go, av, ex, cnt};
		return d;
	endfunction

	function automatic dir_row_t cfg_row(addr_t base, addr_t len);
		dir_row_t d;
		d = row(CMD_NONE, 0, 0, 0, 0, 0);
		d.is_cfg = 1;
		d.cfg_start = base;
		d.cfg_length = len;
		return d;
	endfunction

	// Builds a mostly well-formed command against the current predicted table, predicts its response and sends it.
	task automatic random_item();
		request_t r;
		int       pick;
		int       k;
		addr_t    span;
		response_t res;
		r = '{CMD_ALLOC, rand48(), 1'b1, rand48(), 1'b0, rand48()};
		span = region_len / 8 + 1;
		pick = $urandom_range(99);
		k = -1;
		if (pick < 42) begin
			r.cmd = CMD_ALLOC;
			r.size_given = ($urandom_range(9) != 0);
			r.size = rand48() % span;
			r.offset_given = $urandom_range(1);
			if (r.offset_given && ext_used > 0 && $urandom_range(4) != 0) begin
				k = $urandom_range(ext_used - 1);
				r.offset = ext_off[k] + rand48() % (addr_t'(ext_len[k] + 1) | 1);
			end
			k = -1;
		end else if (pick < 72 && grant_off.size() > 0) begin
			k = $urandom_range(grant_off.size() - 1);
			r.cmd = CMD_FREE;
			r.offset = grant_off[k];
			r.size = grant_len[k];
		end else if (pick < 87 && grant_off.size() > 0) begin
			k = $urandom_range(grant_off.size() - 1);
			r.cmd = CMD_TRIM;
			r.offset = grant_off[k];
			r.size = grant_len[k];
			r.trim = ($urandom_range(7) == 0) ? rand48() : rand48() % (grant_len[k] + 1);
		end else begin
			r.cmd = cmd_t'($urandom_range(3));
			r.size_given = $urandom_range(1);
			r.offset_given = $urandom_range(1);
			if ($urandom_range(1))
				r.size = r.size >> $urandom_range(47);
		end
		pending_rsp.push_back('{ST_OK, 0, 0, 0, 0, 0});
		res = allocator_step(r);
		void'(pending_rsp.pop_back());
		// Replay on a saved copy is not needed: the step above is the only
		// update, so the send below must not predict again.
		pending_rsp.push_back(res);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.req_size <= r.size;
		req_ch.size_given <= r.size_given;
		req_ch.req_offset <= r.offset;
		req_ch.offset_given <= r.offset_given;
		req_ch.trim_amount <= r.trim;
		if (res.status == ST_OK) begin
			if (r.cmd == CMD_ALLOC) begin
				grant_off.push_back(res.goffset);
				grant_len.push_back(res.gsize);
			end else if (r.cmd == CMD_FREE && k >= 0) begin
				grant_off.delete(k);
				grant_len.delete(k);
			end else if (r.cmd == CMD_TRIM && k >= 0) begin
				grant_len[k] = res.gsize;
			end
		end
		do
			@(posedge clk);
		while (!req_ch.ready);
		sent_cnt++;
		if ($urandom_range(99) < tx_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin
		addr_t bases [PHASES];
		addr_t lens [PHASES];
		arst_n = 1'b0;
		errors = 0;
		sent_cnt = 0;
		rsp_cnt = 0;
		cycles = 0;
		tx_idle = 30;
		rx_idle = 68;
		hold_req = 0;
		region_base = '0;
		region_len = '0;
		table_load();
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_ALLOC;
		req_ch.req_size <= '0;
		req_ch.size_given <= 1'b0;
		req_ch.req_offset <= '0;
		req_ch.offset_given <= 1'b0;
		req_ch.trim_amount <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_START;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table after reset, then wraps at the full address width.
		dir_tab.push_back(row(CMD_ALLOC, 5, 1, 0, 0, 0, 1, ST_NO_SPACE, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(CMD_NONE, AMAX, 1, AMAX, 1, AMAX, 1, ST_OK, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(CMD_FREE, 'h10, 0, 'h100, 0, 0, 1, ST_OK, 0, 0, 'h10, 1, 8'hFF));
		dir_tab.push_back(row(CMD_TRIM, 'h20, 0, 'h80, 0, 0, 1, ST_OK, 'h20, 0, 'h10, 1, 8'hFF));
		dir_tab.push_back(row(CMD_TRIM, 'h20, 0, 'hE0, 0, 'h40, 1, ST_OK, 0, 0, 'h30, 1, 8'hFF));
		dir_tab.push_back(row(CMD_ALLOC, 0, 0, 0, 1, 0, 1, ST_OK, 'h30, 'hE0, 0, 0, 0));
		dir_tab.push_back(row(CMD_ALLOC, 0, 0, 0, 0, 0, 1, ST_NO_SPACE, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(CMD_FREE, AMAX, 0, 0, 0, 0, 1, ST_OK, 0, 0, AMAX, 1, 8'hFF));
		dir_tab.push_back(row(CMD_ALLOC, AMAX, 1, 0, 0, 0, 1, ST_OK, AMAX, 0, 0, 0, 0));
		dir_tab.push_back(row(CMD_FREE, 0, 0, AMAX, 0, 0));
		dir_tab.push_back(cfg_row('h1000, 'h1000));
		dir_tab.push_back(row(CMD_ALLOC, 'h100, 1, 0, 0, 0));
		dir_tab.push_back(row(CMD_ALLOC, 'h100, 1, 'h1800, 1, 0));
		dir_tab.push_back(row(CMD_ALLOC, 'h100, 1, 'h1850, 1, 0));
		dir_tab.push_back(row(CMD_ALLOC, 'h900, 1, 0, 0, 0));
		dir_tab.push_back(row(CMD_ALLOC, 'h1001, 1, 0, 0, 0));
		dir_tab.push_back(row(CMD_ALLOC, 'h100, 1, 'h1E00, 1, 0));
		dir_tab.push_back(row(CMD_FREE, 'h100, 0, 'h1000, 0, 0));
		dir_tab.push_back(row(CMD_FREE, 'h100, 0, 'h1800, 0, 0));
		dir_tab.push_back(row(CMD_TRIM, 'h40, 0, 'h1DC0, 0, 'h10));
		dir_tab.push_back(row(CMD_ALLOC, 0, 0, 'h1234, 1, 0));
		for (int i = 0; i < DEPTH + 2; i++)
			dir_tab.push_back(row(CMD_FREE, 1, 0, 'h4000 + 'h10 * i, 0, 0));
		dir_tab.push_back(row(CMD_ALLOC, 2, 1, 'h4001, 1, 0));
		dir_tab.push_back(row(CMD_TRIM, 8, 0, 'h5000, 0, 4));

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				load_region(dir_tab[i].cfg_start, dir_tab[i].cfg_length);
			else
				send(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].rs);
		end

		bases = '{'h1000, 0, 48'hFFFF_FFFF_F000, rand48(), 0, rand48()};
		lens = '{'h1000, AMAX, 'h2000, $urandom_range('h10000, 1), 0, rand48()};
		for (int ph = 0; ph < PHASES; ph++) begin
			load_region(bases[ph], lens[ph]);
			case (ph % 3)
				0: begin
					tx_idle = 30;
					rx_idle = 68;
				end
				1: begin
					tx_idle = 68;
					rx_idle = 30;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			if (ph == 2)
				hold_req = 1;
			for (int n = 0; n < RAND_ITEMS; n++) begin
				if (ph == 3 && n == RAND_ITEMS / 2)
					wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, pending_rsp.size());
			errors++;
		end
		$display("Sent %0d commands over %0d region setups, checked %0d responses.",
			sent_cnt, PHASES + 2, rsp_cnt);
		$display("Statuses seen: ok %0d, no space %0d, no fit %0d, offset %0d, full %0d.",
			status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_NO_FIT],
			status_seen[ST_OFF_FIT], status_seen[ST_FULL]);
		if (errors == 0)
			$display("extent_free_list_allocator verification clean");
		else
			$display("extent_free_list_allocator verification failed");
		$finish;
	end

endmodule
